// ===== hw/rtl/rbfh_pkg.sv =====
package rbfh_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 16;
    localparam int NUM_AXES        = 3;
    localparam int NUM_FACES       = 6;
    localparam int CFG_IDX_W       = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_ORIGIN_Z,
        CFG_DIR_X,
        CFG_DIR_Y,
        CFG_DIR_Z
    } cfg_reg_t;

    // j-th axis crossing axis a (j = 0, 1)
    function automatic int cross_axis(input int a, input int j);
        int s;
        begin
            s = a + 1 + j;
            if (s >= NUM_AXES)
            begin
                s = s - NUM_AXES;
            end
            return s;
        end
    endfunction

endpackage

// ===== hw/rtl/rbfh_prep.sv =====
module rbfh_prep
    import rbfh_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [W-1:0] box_min  [NUM_AXES],
    input  logic        [W-2:0] box_ext  [NUM_AXES],
    input  logic signed [W-1:0] in_best,
    input  logic        [2:0]   in_face,
    input  logic signed [W-1:0] org      [NUM_AXES],
    input  logic signed [W-1:0] dir      [NUM_AXES],
    output logic                out_valid,
    output logic        [W+2:0] num      [NUM_FACES],
    output logic        [W-1:0] den      [NUM_FACES],
    output logic [NUM_FACES-1:0] cand,
    output logic signed [W-1:0] lo       [NUM_AXES],
    output logic signed [W:0]   hi       [NUM_AXES],
    output logic signed [W-1:0] out_best,
    output logic        [2:0]   out_face
);

    // stage A: register the beat and form the max corner
    logic                va_reg;
    logic signed [W-1:0] lo_a_reg   [NUM_AXES];
    logic signed [W:0]   hi_a_reg   [NUM_AXES];
    logic signed [W-1:0] best_a_reg;
    logic        [2:0]   face_a_reg;

    // stage B: gaps, divisors and candidate flags
    logic                 vb_reg;
    logic         [W+2:0] num_reg    [NUM_FACES];
    logic         [W-1:0] den_reg    [NUM_FACES];
    logic [NUM_FACES-1:0] cand_reg;
    logic signed  [W-1:0] lo_b_reg   [NUM_AXES];
    logic signed  [W:0]   hi_b_reg   [NUM_AXES];
    logic signed  [W-1:0] best_b_reg;
    logic         [2:0]   face_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            best_a_reg <= in_best;
            face_a_reg <= in_face;
            best_b_reg <= best_a_reg;
            face_b_reg <= face_a_reg;
        end
    end

    for (genvar k = 0; k < NUM_AXES; k++)
    begin : g_axis
        logic signed [W+1:0] gap_lo;
        logic signed [W+1:0] gap_hi;
        logic        [W-1:0] dir_neg;

        // lo - origin for the near face, origin - hi for the far face
        assign gap_lo  = (W+2)'(lo_a_reg[k]) - (W+2)'(org[k]);
        assign gap_hi  = (W+2)'(org[k]) - (W+2)'(hi_a_reg[k]);
        assign dir_neg = W'(-dir[k]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_a_reg[k] <= box_min[k];
                hi_a_reg[k] <= (W+1)'(box_min[k]) + $signed({2'b00, box_ext[k]});
                lo_b_reg[k] <= lo_a_reg[k];
                hi_b_reg[k] <= hi_a_reg[k];
                num_reg[2*k]    <= {1'b0, gap_lo};
                num_reg[2*k+1]  <= {1'b0, gap_hi};
                den_reg[2*k]    <= dir[k];
                den_reg[2*k+1]  <= dir_neg;
                cand_reg[2*k]   <= (gap_lo > 0) && (dir[k] > 0);
                cand_reg[2*k+1] <= (gap_hi > 0) && (dir[k] < 0);
            end
        end

        assign lo[k] = lo_b_reg[k];
        assign hi[k] = hi_b_reg[k];
    end

    for (genvar f = 0; f < NUM_FACES; f++)
    begin : g_face
        assign num[f] = num_reg[f];
        assign den[f] = den_reg[f];
    end

    assign out_valid = vb_reg;
    assign cand      = cand_reg;
    assign out_best  = best_b_reg;
    assign out_face  = face_b_reg;

endmodule

// ===== hw/rtl/rbfh_div.sv =====
module rbfh_div
    import rbfh_pkg::*;
#(
    parameter int W      = COORD_WIDTH_DEF,
    parameter int SIDE_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W+2:0]      in_num  [NUM_FACES],
    input  logic [W-1:0]      in_den  [NUM_FACES],
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [W-2:0]      out_q   [NUM_FACES],
    output logic [SIDE_W-1:0] out_side
);

    // one quotient bit per stage; quotient saturates at 2^(W-1)-1
    localparam int ITERS = W + FRAC_BITS + 3;

    logic              v_reg    [ITERS];
    logic [SIDE_W-1:0] side_reg [ITERS];
    logic [W+2:0]      num_reg  [ITERS][NUM_FACES];
    logic [W-1:0]      den_reg  [ITERS][NUM_FACES];
    logic [W-1:0]      rem_reg  [ITERS][NUM_FACES];
    logic [W-2:0]      q_reg    [ITERS][NUM_FACES];
    logic              sat_reg  [ITERS][NUM_FACES];

    for (genvar s = 0; s < ITERS; s++)
    begin : g_stage
        localparam int NB = ITERS - 1 - s - FRAC_BITS;

        logic              v_p;
        logic [SIDE_W-1:0] side_p;

        if (s == 0)
        begin : g_first
            assign v_p    = in_valid;
            assign side_p = in_side;
        end
        else
        begin : g_next
            assign v_p    = v_reg[s-1];
            assign side_p = side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s] <= side_p;
            end
        end

        for (genvar f = 0; f < NUM_FACES; f++)
        begin : g_lane
            logic [W+2:0] num_p;
            logic [W-1:0] den_p;
            logic [W-1:0] rem_p;
            logic [W-2:0] q_p;
            logic         sat_p;
            logic         nbit;
            logic [W:0]   sh;
            logic [W:0]   diff;
            logic         ge;

            if (s == 0)
            begin : g_first
                assign num_p = in_num[f];
                assign den_p = in_den[f];
                assign rem_p = '0;
                assign q_p   = '0;
                assign sat_p = 1'b0;
            end
            else
            begin : g_next
                assign num_p = num_reg[s-1][f];
                assign den_p = den_reg[s-1][f];
                assign rem_p = rem_reg[s-1][f];
                assign q_p   = q_reg[s-1][f];
                assign sat_p = sat_reg[s-1][f];
            end

            // numerator bit, zeros for the fraction scaling
            if (NB >= 0)
            begin : g_bit
                assign nbit = num_p[NB];
            end
            else
            begin : g_zero
                assign nbit = 1'b0;
            end

            // restoring step
            assign sh   = {rem_p, nbit};
            assign ge   = sh >= {1'b0, den_p};
            assign diff = sh - {1'b0, den_p};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[s][f] <= num_p;
                    den_reg[s][f] <= den_p;
                    rem_reg[s][f] <= ge ? diff[W-1:0] : sh[W-1:0];
                    q_reg[s][f]   <= {q_p[W-3:0], ge};
                    sat_reg[s][f] <= sat_p | q_p[W-2];
                end
            end
        end
    end

    for (genvar f = 0; f < NUM_FACES; f++)
    begin : g_out
        assign out_q[f] = sat_reg[ITERS-1][f] ? '1 : q_reg[ITERS-1][f];
    end

    assign out_valid = v_reg[ITERS-1];
    assign out_side  = side_reg[ITERS-1];

endmodule

// ===== hw/rtl/rbfh_check.sv =====
module rbfh_check
    import rbfh_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic         [W-2:0] face_dist [NUM_FACES],
    input  logic [NUM_FACES-1:0] cand,
    input  logic signed  [W-1:0] lo       [NUM_AXES],
    input  logic signed  [W:0]   hi       [NUM_AXES],
    input  logic signed  [W-1:0] in_best,
    input  logic         [2:0]   in_face,
    input  logic signed  [W-1:0] org      [NUM_AXES],
    input  logic signed  [W-1:0] dir      [NUM_AXES],
    output logic                 out_valid,
    output logic                 hit,
    output logic signed  [W-1:0] new_distance,
    output logic         [2:0]   new_face
);

    localparam int PW = 2*W - FRAC_BITS;
    localparam int PX = PW + 1;

    // stage M1: distance times cross direction
    logic                 vm1_reg;
    logic signed [2*W-1:0] prod_reg [NUM_FACES][2];
    logic         [W-2:0] d1_reg    [NUM_FACES];
    logic [NUM_FACES-1:0] cand1_reg;
    logic signed  [W-1:0] lo1_reg   [NUM_AXES];
    logic signed  [W:0]   hi1_reg   [NUM_AXES];
    logic signed  [W-1:0] best1_reg;
    logic         [2:0]   face1_reg;

    // stage M2: hit point on face
    logic                 vm2_reg;
    logic         [W-2:0] d2_reg    [NUM_FACES];
    logic [NUM_FACES-1:0] ok2_reg;
    logic [NUM_FACES-1:0] ok_next;
    logic signed  [W-1:0] best2_reg;
    logic         [2:0]   face2_reg;

    // select chain, one face per stage in face order
    logic                 vs_reg    [NUM_FACES];
    logic         [W-2:0] ds_reg    [NUM_FACES][NUM_FACES];
    logic [NUM_FACES-1:0] oks_reg   [NUM_FACES];
    logic signed  [W-1:0] bests_reg [NUM_FACES];
    logic         [2:0]   faces_reg [NUM_FACES];
    logic                 hits_reg  [NUM_FACES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
        end
        else if (en)
        begin
            vm1_reg <= in_valid;
            vm2_reg <= vm1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cand1_reg <= cand;
            best1_reg <= in_best;
            face1_reg <= in_face;
            ok2_reg   <= ok_next;
            best2_reg <= best1_reg;
            face2_reg <= face1_reg;
        end
    end

    for (genvar k = 0; k < NUM_AXES; k++)
    begin : g_box
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo1_reg[k] <= lo[k];
                hi1_reg[k] <= hi[k];
            end
        end
    end

    for (genvar f = 0; f < NUM_FACES; f++)
    begin : g_face
        localparam int A = f / 2;

        logic signed [W-1:0] ds;
        logic [1:0]          inb;

        assign ds = $signed({1'b0, face_dist[f]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d1_reg[f] <= face_dist[f];
                d2_reg[f] <= d1_reg[f];
            end
        end

        for (genvar j = 0; j < 2; j++)
        begin : g_cross
            localparam int K = cross_axis(A, j);

            logic signed [2*W-1:0] prod_next;
            logic signed [PW-1:0]  sc;
            logic signed [PX-1:0]  pt;

            assign prod_next = ds * dir[K];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[f][j] <= prod_next;
                end
            end

            // floor(d * dir / 2^16) plus origin, then half-open bounds
            assign sc     = prod_reg[f][j][2*W-1:FRAC_BITS];
            assign pt     = PX'(org[K]) + PX'(sc);
            assign inb[j] = (pt >= PX'(lo1_reg[K])) && (pt < PX'(hi1_reg[K]));
        end

        assign ok_next[f] = cand1_reg[f] && inb[0] && inb[1];
    end

    for (genvar s = 0; s < NUM_FACES; s++)
    begin : g_sel
        logic                 v_p;
        logic         [W-2:0] d_p [NUM_FACES];
        logic [NUM_FACES-1:0] ok_p;
        logic signed  [W-1:0] best_p;
        logic         [2:0]   face_p;
        logic                 hit_p;
        logic                 take;

        if (s == 0)
        begin : g_first
            assign v_p    = vm2_reg;
            assign d_p    = d2_reg;
            assign ok_p   = ok2_reg;
            assign best_p = best2_reg;
            assign face_p = face2_reg;
            assign hit_p  = 1'b0;
        end
        else
        begin : g_next
            assign v_p    = vs_reg[s-1];
            assign d_p    = ds_reg[s-1];
            assign ok_p   = oks_reg[s-1];
            assign best_p = bests_reg[s-1];
            assign face_p = faces_reg[s-1];
            assign hit_p  = hits_reg[s-1];
        end

        // nearer than running best replaces it
        assign take = ok_p[s] && ($signed({1'b0, d_p[s]}) < best_p);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vs_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vs_reg[s] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ds_reg[s]    <= d_p;
                oks_reg[s]   <= ok_p;
                bests_reg[s] <= take ? $signed({1'b0, d_p[s]}) : best_p;
                faces_reg[s] <= take ? 3'(s) : face_p;
                hits_reg[s]  <= hit_p | take;
            end
        end
    end

    assign out_valid    = vs_reg[NUM_FACES-1];
    assign hit          = hits_reg[NUM_FACES-1];
    assign new_distance = bests_reg[NUM_FACES-1];
    assign new_face     = faces_reg[NUM_FACES-1];

endmodule

// ===== hw/rtl/ray_box_face_hit_unit.sv =====
// Ray versus axis-aligned box face test with nearest-hit tracking.
// Config: load the ray origin and direction through cfg_valid/cfg_ready,
// cfg_index selecting the register (origin x,y,z then direction x,y,z).
// cfg_ready is always high; write only while no box beat is in flight.
// Input: one box beat (min corner, extents, best distance and face so far)
// is taken at each edge with in_valid high and in_stall low.
// Output: one result beat per box (hit, new_distance, new_face), taken at
// each edge with out_valid high and out_stall low.
// Throughput: one box per cycle while not stalled. Stages: the
// bit-per-stage divider (COORD_WIDTH + 19 stages, six faces in
// parallel), two setup stages, two hit-point stages and six select stages.
// Stall: when a finished result is held and out_stall is high, the whole
// pipeline freezes and in_stall is raised; nothing is dropped or repeated.
// Reset: all stage valids clear, ray registers return to zero.
module ray_box_face_hit_unit
    import rbfh_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic        [CFG_IDX_W-1:0]   cfg_index,
    input  logic        [COORD_WIDTH-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] box_min_x,
    input  logic signed [COORD_WIDTH-1:0] box_min_y,
    input  logic signed [COORD_WIDTH-1:0] box_min_z,
    input  logic        [COORD_WIDTH-2:0] box_width,
    input  logic        [COORD_WIDTH-2:0] box_height,
    input  logic        [COORD_WIDTH-2:0] box_depth,
    input  logic signed [COORD_WIDTH-1:0] best_distance,
    input  logic        [2:0]             best_face,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] new_distance,
    output logic        [2:0]             new_face
);

    localparam int W      = COORD_WIDTH;
    localparam int SIDE_W = 7*W + 12;

    logic signed [W-1:0] org_reg [NUM_AXES];
    logic signed [W-1:0] dir_reg [NUM_AXES];
    logic                en;

    // config write port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                org_reg[k] <= '0;
                dir_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ORIGIN_X: org_reg[0] <= cfg_data;
                CFG_ORIGIN_Y: org_reg[1] <= cfg_data;
                CFG_ORIGIN_Z: org_reg[2] <= cfg_data;
                CFG_DIR_X:    dir_reg[0] <= cfg_data;
                CFG_DIR_Y:    dir_reg[1] <= cfg_data;
                CFG_DIR_Z:    dir_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: freeze only when the held result is stalled
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    logic signed [W-1:0] box_min [NUM_AXES];
    logic        [W-2:0] box_ext [NUM_AXES];

    assign box_min[0] = box_min_x;
    assign box_min[1] = box_min_y;
    assign box_min[2] = box_min_z;
    assign box_ext[0] = box_width;
    assign box_ext[1] = box_height;
    assign box_ext[2] = box_depth;

    // setup stages
    logic                 p_valid;
    logic         [W+2:0] p_num  [NUM_FACES];
    logic         [W-1:0] p_den  [NUM_FACES];
    logic [NUM_FACES-1:0] p_cand;
    logic signed  [W-1:0] p_lo   [NUM_AXES];
    logic signed  [W:0]   p_hi   [NUM_AXES];
    logic signed  [W-1:0] p_best;
    logic         [2:0]   p_face;

    rbfh_prep #(
        .W (W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .box_min   (box_min),
        .box_ext   (box_ext),
        .in_best   (best_distance),
        .in_face   (best_face),
        .org       (org_reg),
        .dir       (dir_reg),
        .out_valid (p_valid),
        .num       (p_num),
        .den       (p_den),
        .cand      (p_cand),
        .lo        (p_lo),
        .hi        (p_hi),
        .out_best  (p_best),
        .out_face  (p_face)
    );

    // box data rides alongside the divider
    logic [SIDE_W-1:0] p_side;
    logic [SIDE_W-1:0] d_side;

    assign p_side = {p_cand, p_face, p_best, p_hi[2], p_hi[1], p_hi[0],
                     p_lo[2], p_lo[1], p_lo[0]};

    logic                 d_valid;
    logic         [W-2:0] d_q    [NUM_FACES];
    logic [NUM_FACES-1:0] d_cand;
    logic signed  [W-1:0] d_lo   [NUM_AXES];
    logic signed  [W:0]   d_hi   [NUM_AXES];
    logic signed  [W-1:0] d_best;
    logic         [2:0]   d_face;

    rbfh_div #(
        .W      (W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid),
        .in_num    (p_num),
        .in_den    (p_den),
        .in_side   (p_side),
        .out_valid (d_valid),
        .out_q     (d_q),
        .out_side  (d_side)
    );

    assign {d_cand, d_face, d_best, d_hi[2], d_hi[1], d_hi[0],
            d_lo[2], d_lo[1], d_lo[0]} = d_side;

    // hit point test and nearest-face select
    rbfh_check #(
        .W (W)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (d_valid),
        .face_dist    (d_q),
        .cand         (d_cand),
        .lo           (d_lo),
        .hi           (d_hi),
        .in_best      (d_best),
        .in_face      (d_face),
        .org          (org_reg),
        .dir          (dir_reg),
        .out_valid    (out_valid),
        .hit          (hit),
        .new_distance (new_distance),
        .new_face     (new_face)
    );

endmodule

// ===== bench/ray_box_face_hit_unit_tb.sv =====
`timescale 1ns / 1ps

module ray_box_face_hit_unit_tb;
    import rbfh_pkg::*;

    localparam int CW         = COORD_WIDTH_DEF;
    localparam int PIPE_DEPTH = CW + 29;
    localparam int DRAIN_WAIT = PIPE_DEPTH + 10;
    localparam int CYCLE_CAP  = 400000;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_LEN  = 128;
    localparam longint DIST_MAX = (longint'(1) << (CW - 1)) - 1;

    typedef struct {
        logic [CW-1:0] min_x, min_y, min_z;
        logic [CW-2:0] width, height, depth;
        logic [CW-1:0] best;
        logic [2:0]    face;
    } box_t;

    typedef struct {
        logic          hit;
        logic [CW-1:0] distance;
        logic [2:0]    face;
    } face_hit_t;

    typedef struct {
        box_t      box;
        bit        typed;
        face_hit_t res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CW-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [CW-1:0] box_min_x, box_min_y, box_min_z;
    logic [CW-2:0] box_width, box_height, box_depth;
    logic signed [CW-1:0] best_distance;
    logic [2:0] best_face;
    logic out_valid;
    logic out_stall;
    logic hit;
    logic signed [CW-1:0] new_distance;
    logic [2:0] new_face;

    // local copy of the ray registers
    longint ray_org[3];
    longint ray_dir[3];

    face_hit_t hits_pending[$];
    int  mismatches;
    int  boxes_sent;
    int  results_seen;
    int  hits_seen;
    int  cycles;
    int  idle_max;
    int  hold_req;
    dir_row_t dir_rows[$];

    ray_box_face_hit_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
        .box_width(box_width), .box_height(box_height), .box_depth(box_depth),
        .best_distance(best_distance), .best_face(best_face),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .new_distance(new_distance), .new_face(new_face)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // nearest face hit over the six faces, in order -x,+x,-y,+y,-z,+z
    function automatic face_hit_t nearest_face(box_t b);
        face_hit_t r;
        longint lo[3];
        longint hi[3];
        longint best, plane, num, den, d, p;
        bit cand, on_face;
        int a;
        lo[0] = longint'(signed'(b.min_x));
        lo[1] = longint'(signed'(b.min_y));
        lo[2] = longint'(signed'(b.min_z));
        hi[0] = lo[0] + longint'(b.width);
        hi[1] = lo[1] + longint'(b.height);
        hi[2] = lo[2] + longint'(b.depth);
        best = longint'(signed'(b.best));
        r.hit = 1'b0;
        r.face = b.face;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            a = f / 2;
            if (f % 2 == 0)
            begin
                plane = lo[a];
                cand = (ray_org[a] < plane) && (ray_dir[a] > 0);
                num = plane - ray_org[a];
                den = ray_dir[a];
            end
            else
            begin
                plane = hi[a];
                cand = (ray_org[a] > plane) && (ray_dir[a] < 0);
                num = ray_org[a] - plane;
                den = -ray_dir[a];
            end
            if (cand)
            begin
                d = (num <<< FRAC_BITS) / den;
                if (d > DIST_MAX)
                    d = DIST_MAX;
                if (d < best)
                begin
                    on_face = 1'b1;
                    for (int k = 0; k < NUM_AXES; k++)
                    begin
                        if (k != a)
                        begin
                            p = ray_org[k] + ((d * ray_dir[k]) >>> FRAC_BITS);
                            if (!(p >= lo[k] && p < hi[k]))
                                on_face = 1'b0;
                        end
                    end
                    if (on_face)
                    begin
                        best = d;
                        r.face = 3'(f);
                        r.hit = 1'b1;
                    end
                end
            end
        end
        r.distance = best[CW-1:0];
        return r;
    endfunction

    // one register beat; caller lowers cfg_valid after the last one
    task automatic write_reg(cfg_reg_t idx, logic [CW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        if (idx <= CFG_ORIGIN_Z)
            ray_org[idx] = longint'(signed'(v));
        else
            ray_dir[idx - CFG_DIR_X] = longint'(signed'(v));
    endtask

    task automatic load_ray(logic [CW-1:0] ox, oy, oz, dx, dy, dz);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_DIR_X, dx);
        write_reg(CFG_DIR_Y, dy);
        write_reg(CFG_DIR_Z, dz);
        cfg_valid <= 1'b0;
    endtask

    // wait for every pending result, then let the pipe empty
    task automatic drain;
        while (hits_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // drive one box beat; the expected result is queued at acceptance
    task automatic send_box(box_t b, bit typed, face_hit_t r);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        box_min_x     <= b.min_x;
        box_min_y     <= b.min_y;
        box_min_z     <= b.min_z;
        box_width     <= b.width;
        box_height    <= b.height;
        box_depth     <= b.depth;
        best_distance <= b.best;
        best_face     <= b.face;
        do @(posedge clk); while (in_stall);
        hits_pending.push_back(typed ? r : nearest_face(b));
        boxes_sent++;
    endtask

    function automatic logic [CW-1:0] rand_near(int span);
        return CW'($urandom_range(0, 2 * span)) - CW'(span);
    endfunction

    // mostly boxes placed around a point on the ray, some pure noise
    function automatic box_t make_box();
        box_t b;
        longint t;
        b.face = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 3)
        begin
            b.min_x  = $urandom;
            b.min_y  = $urandom;
            b.min_z  = $urandom;
            b.width  = $urandom;
            b.height = $urandom;
            b.depth  = $urandom;
            b.best   = $urandom;
        end
        else
        begin
            t = longint'($urandom_range(0, 64 << FRAC_BITS));
            b.min_x  = CW'(ray_org[0] + ((t * ray_dir[0]) >>> FRAC_BITS)) - CW'($urandom_range(0, 4 << FRAC_BITS));
            b.min_y  = CW'(ray_org[1] + ((t * ray_dir[1]) >>> FRAC_BITS)) - CW'($urandom_range(0, 4 << FRAC_BITS));
            b.min_z  = CW'(ray_org[2] + ((t * ray_dir[2]) >>> FRAC_BITS)) - CW'($urandom_range(0, 4 << FRAC_BITS));
            b.width  = (CW-1)'($urandom_range(0, 8 << FRAC_BITS));
            b.height = (CW-1)'($urandom_range(0, 8 << FRAC_BITS));
            b.depth  = (CW-1)'($urandom_range(0, 8 << FRAC_BITS));
            b.best   = ($urandom_range(0, 1) == 0) ? CW'(DIST_MAX)
                                                   : CW'($urandom_range(0, 80 << FRAC_BITS));
        end
        return b;
    endfunction

    function automatic dir_row_t mk_row(logic [CW-1:0] mx, my, mz, logic [CW-2:0] w, h, dp,
                                        logic [CW-1:0] bd, logic [2:0] bf, bit typed,
                                        logic eh, logic [CW-1:0] ed, logic [2:0] ef);
        dir_row_t r;
        r.box.min_x = mx; r.box.min_y = my; r.box.min_z = mz;
        r.box.width = w;  r.box.height = h; r.box.depth = dp;
        r.box.best = bd;  r.box.face = bf;
        r.typed = typed;
        r.res.hit = eh; r.res.distance = ed; r.res.face = ef;
        return r;
    endfunction

    // result side: random stalls, one long hold on request
    initial
    begin
        face_hit_t e;
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = (hold_req > 0) ? hold_req : $urandom_range(0, idle_max);
            hold_req = 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            results_seen++;
            if (hits_pending.size() == 0)
            begin
                $display("%0t: result beat with nothing pending", $time);
                mismatches++;
            end
            else
            begin
                e = hits_pending.pop_front();
                if (hit === 1'b1)
                    hits_seen++;
                if (hit !== e.hit)
                begin
                    $display("%0t: hit exp %0b got %0b", $time, e.hit, hit);
                    mismatches++;
                end
                if (new_distance !== e.distance)
                begin
                    $display("%0t: new_distance exp %h got %h", $time, e.distance,
                             new_distance);
                    mismatches++;
                end
                if (new_face !== e.face)
                begin
                    $display("%0t: new_face exp %0d got %0d", $time, e.face, new_face);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        face_hit_t nores;
        localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;
        logic [CW-1:0] ox, oy, oz, dx, dy, dz;
        int split;
        mismatches = 0; boxes_sent = 0; results_seen = 0; hits_seen = 0;
        cycles = 0; idle_max = 18; hold_req = 0;
        nores = '{1'b0, '0, '0};
        for (int k = 0; k < NUM_AXES; k++)
        begin
            ray_org[k] = 0;
            ray_dir[k] = 0;
        end
        rst_n = 1'b0;
        cfg_valid <= 1'b0; cfg_index <= CFG_ORIGIN_X; cfg_data <= '0;
        in_valid <= 1'b0;
        box_min_x <= '0; box_min_y <= '0; box_min_z <= '0;
        box_width <= '0; box_height <= '0; box_depth <= '0;
        best_distance <= '0; best_face <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero ray after reset: nothing hits, fields pass through
        dir_rows.push_back(mk_row('0, '0, '0, '0, '0, '0, '0, 3'd0, 1, 1'b0, '0, 3'd0));
        dir_rows.push_back(mk_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
            31'h7fffffff, 31'h7fffffff, 32'h80000000, 3'd7, 1, 1'b0, 32'h80000000, 3'd7));
        dir_rows.push_back(mk_row(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff,
            31'h7fffffff, 31'h7fffffff, 32'h7fffffff, 3'd6, 1, 1'b0, 32'h7fffffff, 3'd6));
        dir_rows.push_back(mk_row(32'hffff0000, 32'hffff0000, 32'hffff0000, 31'h20000,
            31'h20000, 31'h20000, 32'h7fffffff, 3'd5, 1, 1'b0, 32'h7fffffff, 3'd5));
        split = dir_rows.size();
        // ray along +x from the origin
        dir_rows.push_back(mk_row(5 * ONE, -ONE, -ONE, 31'h20000, 31'h20000, 31'h20000,
            32'h7fffffff, 3'd0, 1, 1'b1, 32'h50000, 3'd0));
        // not nearer than best: passes through
        dir_rows.push_back(mk_row(5 * ONE, -ONE, -ONE, 31'h20000, 31'h20000, 31'h20000,
            32'h50000, 3'd3, 1, 1'b0, 32'h50000, 3'd3));
        // hit point on the min edge (inclusive), on the max edge (exclusive)
        dir_rows.push_back(mk_row(3 * ONE, '0, -ONE, 31'h20000, 31'h20000, 31'h20000,
            32'h7fffffff, 3'd1, 0, 1'b0, '0, 3'd0));
        dir_rows.push_back(mk_row(3 * ONE, -2 * ONE, -ONE, 31'h20000, 31'h20000, 31'h20000,
            32'h7fffffff, 3'd1, 0, 1'b0, '0, 3'd0));
        // origin on the plane, box behind, zero extents, negative and zero best, box at the x limit
        dir_rows.push_back(mk_row('0, -ONE, -ONE, 31'h20000, 31'h20000, 31'h20000,
            32'h7fffffff, 3'd2, 0, 1'b0, '0, 3'd0));
        dir_rows.push_back(mk_row(-3 * ONE, -ONE, -ONE, 31'h20000, 31'h20000, 31'h20000,
            32'h7fffffff, 3'd2, 0, 1'b0, '0, 3'd0));
        dir_rows.push_back(mk_row(2 * ONE, '0, '0, '0, '0, '0, 32'h7fffffff, 3'd4, 0,
            1'b0, '0, 3'd0));
        dir_rows.push_back(mk_row(2 * ONE, -ONE, -ONE, 31'h20000, 31'h20000, 31'h20000,
            32'hffffffff, 3'd4, 0, 1'b0, '0, 3'd0));
        dir_rows.push_back(mk_row(1, -ONE, -ONE, 31'h7fffffff, 31'h20000, 31'h20000,
            '0, 3'd6, 0, 1'b0, '0, 3'd0));
        dir_rows.push_back(mk_row(32'h7fffffff, -ONE, -ONE, 31'h1, 31'h20000, 31'h20000,
            32'h7fffffff, 3'd1, 0, 1'b0, '0, 3'd0));

        // directed part
        for (int i = 0; i < dir_rows.size(); i++)
        begin
            if (i == split)
            begin
                in_valid <= 1'b0;
                drain();
                load_ray('0, '0, '0, ONE, '0, '0);
            end
            send_box(dir_rows[i].box, dir_rows[i].typed, dir_rows[i].res);
        end

        // random phases, each under its own ray
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            in_valid <= 1'b0;
            drain();
            case (ph)
                0: begin
                    ox = 32'h80000000; oy = 32'h80000000; oz = 32'h80000000;
                    dx = 32'h7fffffff; dy = 32'h7fffffff; dz = 32'h7fffffff;
                end
                1: begin
                    ox = 32'h7fffffff; oy = 32'h7fffffff; oz = 32'h7fffffff;
                    dx = 32'h80000000; dy = 32'h80000000; dz = 32'h80000000;
                end
                2: begin
                    // tiny steps from far away: quotients saturate
                    ox = 32'h80000000; oy = '0; oz = 32'h7fffffff;
                    dx = 32'h1; dy = 32'h1; dz = 32'hffffffff;
                end
                3: begin
                    ox = $urandom; oy = $urandom; oz = $urandom;
                    dx = $urandom; dy = $urandom; dz = $urandom;
                end
                default: begin
                    ox = rand_near(32 << FRAC_BITS);
                    oy = rand_near(32 << FRAC_BITS);
                    oz = rand_near(32 << FRAC_BITS);
                    dx = rand_near(2 << FRAC_BITS);
                    dy = rand_near(2 << FRAC_BITS);
                    dz = rand_near(2 << FRAC_BITS);
                    if (ph % 3 == 0)
                        dy = '0;
                end
            endcase
            load_ray(ox, oy, oz, dx, dy, dz);
            idle_max = (ph % 4 == 1) ? 0 : 18;
            if (ph == 5)
            begin
                // receiver holds off while boxes stream in back to back
                idle_max = 0;
                hold_req = 400;
            end
            for (int i = 0; i < PHASE_LEN; i++)
                send_box(make_box(), 0, nores);
        end
        in_valid <= 1'b0;
        drain();

        $display("%0d boxes over %0d ray settings, %0d results, %0d hits",
                 boxes_sent, NUM_PHASES + 2, results_seen, hits_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rbfh_pkg.sv
hw/rtl/rbfh_prep.sv
hw/rtl/rbfh_div.sv
hw/rtl/rbfh_check.sv
hw/rtl/ray_box_face_hit_unit.sv
bench/ray_box_face_hit_unit_tb.sv
